@@ hw/rtl/tfv_pkg.sv @@
// ----------------------------------------------------------------------------
// tfv_pkg
// Shared types, register codes, status codes and the CRC byte update for the
// telemetry frame validator.
// ----------------------------------------------------------------------------
package tfv_pkg;

	localparam int TFV_PACKET_BYTES = 48;

	localparam logic [15:0] TFV_CRC_POLY   = 16'h1021;
	localparam logic [31:0] TFV_MAGIC_RST  = 32'h534D_4C54;
	localparam logic [15:0] TFV_SEED_RST   = 16'hFFFF;

	localparam int TFV_ADDR_W = 3;

	// register indexes, decoded from paddr[2]
	localparam logic TFV_REG_MAGIC = 1'b0;
	localparam logic TFV_REG_SEED  = 1'b1;

	// frame status codes
	localparam logic [2:0] TFV_ST_GOOD  = 3'd0;
	localparam logic [2:0] TFV_ST_LEN   = 3'd1;
	localparam logic [2:0] TFV_ST_RFAIL = 3'd2;
	localparam logic [2:0] TFV_ST_MAGIC = 3'd3;
	localparam logic [2:0] TFV_ST_CRC   = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
		logic       read_fail;
	} tfv_beat_t;

	typedef struct packed {
		logic [2:0]  frame_status;
		logic [15:0] packet_sequence;
		logic [31:0] good_count;
		logic [31:0] bad_count;
	} tfv_report_t;

	// CRC-16/CCITT, MSB first, one byte
	function automatic logic [15:0] tfv_crc_byte(input logic [15:0] crc,
		input logic [7:0] b);
		logic [15:0] r;
		r = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (r[15]) begin
				r = {r[14:0], 1'b0} ^ TFV_CRC_POLY;
			end else begin
				r = {r[14:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/tfv_rx_if.sv @@
// ----------------------------------------------------------------------------
// tfv_rx_if
// Byte channel into the validator: valid/ready plus one received frame byte.
// ----------------------------------------------------------------------------
interface tfv_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	logic       read_fail;

	modport source (output valid, data_byte, last_byte, read_fail, input ready);
	modport sink   (input valid, data_byte, last_byte, read_fail, output ready);
endinterface

@@ hw/rtl/tfv_report_if.sv @@
// ----------------------------------------------------------------------------
// tfv_report_if
// Result channel out of the validator: valid/ready plus one frame report.
// ----------------------------------------------------------------------------
interface tfv_report_if;
	logic        valid;
	logic        ready;
	logic [2:0]  frame_status;
	logic [15:0] packet_sequence;
	logic [31:0] good_count;
	logic [31:0] bad_count;

	modport source (output valid, frame_status, packet_sequence, good_count,
		bad_count, input ready);
	modport sink   (input valid, frame_status, packet_sequence, good_count,
		bad_count, output ready);
endinterface

@@ hw/rtl/telemetry_frame_validator.sv @@
// ----------------------------------------------------------------------------
// telemetry_frame_validator
// Byte-serial frame checker: length, read failure, magic word and
// CRC-16/CCITT, with a status report per frame.
// ----------------------------------------------------------------------------
// Feed frame bytes on rx, one per beat, with last_byte set on the final byte
// and read_fail set on any byte of a frame the radio flagged. The block takes
// one byte per clock, save when a last byte stalls: each byte lands in an
// input register, and from there the CRC (one byte-wide update per cycle),
// magic compare, field capture and status decision run in a single pass into
// the report register. Only the last byte of a frame produces a report beat.
// The report is offered on report once the last byte has passed the input
// register and then been loaded into the report register. Bytes keep
// flowing while a report waits to be taken; only a second last byte stalls
// behind an untaken report. Status is 0 good, 1 length mismatch, 2 read
// failure, 3 bad magic, 4 bad CRC, decided in that order. Registers: 0x0 magic
// word (reset 0x534D4C54, first four bytes little-endian), 0x4 CRC seed (reset
// 0xFFFF, taken at each frame's first byte). Write them only while the block
// is idle.
// ----------------------------------------------------------------------------
module telemetry_frame_validator import tfv_pkg::*; #(
	parameter int PACKET_BYTES = TFV_PACKET_BYTES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [TFV_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	tfv_rx_if.sink                rx,
	tfv_report_if.source          report
);

	logic [31:0] magic_word;
	logic [15:0] crc_seed;

	// input stage
	logic        valid_s1;
	tfv_beat_t   beat_s1;
	logic        go_s1;

	// report register
	logic        rep_valid_q;
	tfv_report_t rep_q;
	tfv_report_t chk_report;

	tfv_cfg_regs u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.magic_word (magic_word),
		.crc_seed   (crc_seed)
	);

	// A non-last byte only updates frame state, so it always advances;
	// a last byte advances when the report register is free or draining.
	assign go_s1 = valid_s1 && (!beat_s1.last_byte || !rep_valid_q || report.ready);
	assign rx.ready = !valid_s1 || go_s1;

	tfv_frame_check #(
		.PACKET_BYTES (PACKET_BYTES)
	) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (go_s1),
		.beat       (beat_s1),
		.magic_word (magic_word),
		.crc_seed   (crc_seed),
		.report     (chk_report)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rep_valid_q <= 1'b0;
		end else begin
			// hold the input beat until the check stage consumes it
			if (rx.valid && rx.ready) begin
				valid_s1 <= 1'b1;
			end else if (go_s1) begin
				valid_s1 <= 1'b0;
			end
			// load a report on a last byte, drop it once taken
			if (go_s1 && beat_s1.last_byte) begin
				rep_valid_q <= 1'b1;
			end else if (report.ready) begin
				rep_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			beat_s1.data_byte <= rx.data_byte;
			beat_s1.last_byte <= rx.last_byte;
			beat_s1.read_fail <= rx.read_fail;
		end
		if (go_s1 && beat_s1.last_byte) begin
			rep_q <= chk_report;
		end
	end

	assign report.valid           = rep_valid_q;
	assign report.frame_status    = rep_q.frame_status;
	assign report.packet_sequence = rep_q.packet_sequence;
	assign report.good_count      = rep_q.good_count;
	assign report.bad_count       = rep_q.bad_count;

endmodule

@@ hw/rtl/tfv_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// tfv_cfg_regs
// APB register file: magic word and CRC seed.
// ----------------------------------------------------------------------------
module tfv_cfg_regs import tfv_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [TFV_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output logic [31:0]           magic_word,
	output logic [15:0]           crc_seed
);

	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_word <= TFV_MAGIC_RST;
			crc_seed   <= TFV_SEED_RST;
		end else if (wr_en) begin
			case (paddr[2])
				TFV_REG_MAGIC: magic_word <= pwdata;
				TFV_REG_SEED:  crc_seed   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			TFV_REG_MAGIC: prdata = magic_word;
			TFV_REG_SEED:  prdata = {16'h0000, crc_seed};
			default:       prdata = 32'h0000_0000;
		endcase
	end

endmodule

@@ hw/rtl/tfv_frame_check.sv @@
// ----------------------------------------------------------------------------
// tfv_frame_check
// Per-frame state, byte-wide CRC update, check ordering and saturating
// frame counters.
// ----------------------------------------------------------------------------
module tfv_frame_check import tfv_pkg::*; #(
	parameter int PACKET_BYTES = TFV_PACKET_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  tfv_beat_t   beat,
	input  logic [31:0] magic_word,
	input  logic [15:0] crc_seed,
	output tfv_report_t report
);

	localparam logic [7:0] LAST_POS   = 8'(PACKET_BYTES - 1);
	localparam logic [7:0] CRC_LO_POS = 8'(PACKET_BYTES - 2);
	localparam logic [7:0] SEQ_LO_POS = 8'd6;
	localparam logic [7:0] SEQ_HI_POS = 8'd7;
	localparam logic [7:0] MAGIC_LEN  = 8'd4;

	logic [7:0]  pos_q;
	logic [15:0] crc_q;
	logic        magic_ok_q;
	logic [15:0] rcrc_q;
	logic [15:0] seq_q;
	logic        fail_q;
	logic [31:0] good_q;
	logic [31:0] bad_q;

	logic [15:0] crc_base;
	logic [15:0] crc_next;
	logic [7:0]  magic_byte;
	logic        magic_next;
	logic [15:0] seq_next;
	logic [15:0] rcrc_next;
	logic        fail_next;
	logic [2:0]  status;
	logic [31:0] good_next;
	logic [31:0] bad_next;

	always_comb begin
		crc_base   = (pos_q == 8'd0) ? crc_seed : crc_q;
		magic_byte = 8'(magic_word >> {pos_q[1:0], 3'b000});
		magic_next = magic_ok_q && !((pos_q < MAGIC_LEN) && (beat.data_byte != magic_byte));

		seq_next = seq_q;
		if (pos_q == SEQ_LO_POS) begin
			seq_next = {seq_q[15:8], beat.data_byte};
		end else if (pos_q == SEQ_HI_POS) begin
			seq_next = {beat.data_byte, seq_q[7:0]};
		end

		crc_next  = crc_base;
		rcrc_next = rcrc_q;
		if (pos_q < CRC_LO_POS) begin
			crc_next = tfv_crc_byte(crc_base, beat.data_byte);
		end else if (pos_q == CRC_LO_POS) begin
			rcrc_next = {rcrc_q[15:8], beat.data_byte};
		end else if (pos_q == LAST_POS) begin
			rcrc_next = {beat.data_byte, rcrc_q[7:0]};
		end

		fail_next = fail_q || beat.read_fail;

		if (pos_q != LAST_POS) begin
			status = TFV_ST_LEN;
		end else if (fail_next) begin
			status = TFV_ST_RFAIL;
		end else if (!magic_next) begin
			status = TFV_ST_MAGIC;
		end else if (rcrc_next != crc_next) begin
			status = TFV_ST_CRC;
		end else begin
			status = TFV_ST_GOOD;
		end

		good_next = good_q;
		bad_next  = bad_q;
		if (status == TFV_ST_GOOD) begin
			if (good_q != '1) good_next = good_q + 32'd1;
		end else begin
			if (bad_q != '1) bad_next = bad_q + 32'd1;
		end

		report.frame_status    = status;
		report.packet_sequence = seq_next;
		report.good_count      = good_next;
		report.bad_count       = bad_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= 8'd0;
			crc_q      <= TFV_SEED_RST;
			magic_ok_q <= 1'b1;
			rcrc_q     <= 16'h0000;
			seq_q      <= 16'h0000;
			fail_q     <= 1'b0;
			good_q     <= 32'd0;
			bad_q      <= 32'd0;
		end else if (step) begin
			if (beat.last_byte) begin
				// close the frame: bump a counter, clear per-frame state
				pos_q      <= 8'd0;
				crc_q      <= crc_seed;
				magic_ok_q <= 1'b1;
				rcrc_q     <= 16'h0000;
				seq_q      <= 16'h0000;
				fail_q     <= 1'b0;
				good_q     <= good_next;
				bad_q      <= bad_next;
			end else begin
				if (pos_q != 8'hFF) pos_q <= pos_q + 8'd1;
				crc_q      <= crc_next;
				magic_ok_q <= magic_next;
				rcrc_q     <= rcrc_next;
				seq_q      <= seq_next;
				fail_q     <= fail_next;
			end
		end
	end

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for telemetry_frame_validator: frames of every shape go
// in on rx, each report beat is compared with a local model of the checker.
// ----------------------------------------------------------------------------
// A short table of hand-written frames runs first, right after reset, with
// the report typed in where it is plain. Random frames follow over several
// register settings: well-formed frames with random content take the largest
// share; others carry a corrupted magic word, CRC or read-fail flag, are too
// short or too long, or are pure noise. Both channels idle in random bursts;
// once the report side holds off for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module testbench;
	import tfv_pkg::*;

	localparam int FRAME_LEN    = TFV_PACKET_BYTES;
	localparam int MAX_FRAME    = 258;
	localparam int SETTLE_CYC   = 8;
	localparam int HOLD_CYC     = 300;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int PHASES       = 6;
	localparam int PHASE_BEATS  = 24;
	localparam int PHASE_FRAMES = 1;
	localparam int DIR_ROWS     = 12;

	// one row of the hand-written frame table
	typedef struct {
		int          len;
		logic [15:0] seq;
		bit          bad_magic;
		bit          bad_crc;
		bit          rfail;
		bit          noise;
		bit          typed;
		tfv_report_t exp;
	} frame_row_t;

	logic clk = 1'b0;
	logic arst_n;

	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [TFV_ADDR_W-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	tfv_rx_if     rx_ch ();
	tfv_report_if rpt_ch ();

	telemetry_frame_validator #(
		.PACKET_BYTES(FRAME_LEN)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.rx      (rx_ch),
		.report  (rpt_ch)
	);

	// register shadows
	logic [31:0] cfg_magic;
	logic [15:0] cfg_seed;

	// per-frame state of the checker model
	logic [7:0]  cur_pos;
	logic [15:0] cur_crc;
	logic        magic_ok;
	logic [15:0] trailer_crc;
	logic [15:0] seq_field;
	logic        fail_flag;
	logic [31:0] accepted_cnt;
	logic [31:0] rejected_cnt;

	tfv_report_t frame_reports_due [$];

	// frame under construction
	tfv_beat_t frame_beats [MAX_FRAME];
	int        frame_len;

	// typed report that replaces the model's for the current frame
	bit          report_typed;
	tfv_report_t typed_value;

	frame_row_t dir_table [DIR_ROWS];

	int          errors = 0;
	int          beats_sent = 0;
	int          frames_done = 0;
	int          cycle_count = 0;
	bit          steady_run = 1'b0;
	int          hold_requests = 0;
	int          holds_served = 0;
	int          hold_left = 0;
	int          sink_gap = 0;

	// 2-unit clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Abort the run if it never reaches its end.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL telemetry_frame_validator");
			$finish;
		end
	end

	// CRC-16/CCITT byte update, MSB first
	function automatic logic [15:0] ccitt_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] r;
		r = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			r = r[15] ? ({r[14:0], 1'b0} ^ 16'h1021) : {r[14:0], 1'b0};
		end
		return r;
	endfunction

	// Drop the per-frame state back to its start values.
	function automatic void frame_restart();
		cur_pos     = 8'd0;
		cur_crc     = cfg_seed;
		magic_ok    = 1'b1;
		trailer_crc = 16'h0000;
		seq_field   = 16'h0000;
		fail_flag   = 1'b0;
	endfunction

	// Advance the checker model by one accepted byte; return 1 with the
	// report when the byte closes a frame.
	function automatic bit frame_check_step(input tfv_beat_t beat, output tfv_report_t rpt);
		logic [15:0] crc_now;
		logic [2:0]  status;
		int          pos;
		pos     = cur_pos;
		rpt     = '0;
		crc_now = (pos == 0) ? cfg_seed : cur_crc;
		if (pos < 4 && beat.data_byte != cfg_magic[8*pos +: 8]) begin
			magic_ok = 1'b0;
		end
		if (pos == 6) begin
			seq_field[7:0] = beat.data_byte;
		end else if (pos == 7) begin
			seq_field[15:8] = beat.data_byte;
		end
		// CRC covers everything ahead of the trailer; the trailer is captured
		if (pos < FRAME_LEN - 2) begin
			crc_now = ccitt_update(crc_now, beat.data_byte);
		end else if (pos == FRAME_LEN - 2) begin
			trailer_crc[7:0] = beat.data_byte;
		end else if (pos == FRAME_LEN - 1) begin
			trailer_crc[15:8] = beat.data_byte;
		end
		cur_crc = crc_now;
		if (beat.read_fail) begin
			fail_flag = 1'b1;
		end
		if (cur_pos != 8'd255) begin
			cur_pos = cur_pos + 8'd1;
		end
		if (!beat.last_byte) begin
			return 1'b0;
		end
		if (pos != FRAME_LEN - 1) begin
			status = TFV_ST_LEN;
		end else if (fail_flag) begin
			status = TFV_ST_RFAIL;
		end else if (!magic_ok) begin
			status = TFV_ST_MAGIC;
		end else if (trailer_crc != cur_crc) begin
			status = TFV_ST_CRC;
		end else begin
			status = TFV_ST_GOOD;
		end
		if (status == TFV_ST_GOOD) begin
			if (accepted_cnt != 32'hFFFF_FFFF) begin
				accepted_cnt = accepted_cnt + 32'd1;
			end
		end else if (rejected_cnt != 32'hFFFF_FFFF) begin
			rejected_cnt = rejected_cnt + 32'd1;
		end
		rpt.frame_status    = status;
		rpt.packet_sequence = seq_field;
		rpt.good_count      = accepted_cnt;
		rpt.bad_count       = rejected_cnt;
		frame_restart();
		return 1'b1;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			errors++;
		end
	endtask

	// Compare each report beat with the oldest expected report.
	always @(posedge clk) begin
		tfv_report_t want;
		if (arst_n === 1'b1 && rpt_ch.valid === 1'b1 && rpt_ch.ready === 1'b1) begin
			if (frame_reports_due.size() == 0) begin
				$error("report beat with no frame pending: status %0d seq %0h",
					rpt_ch.frame_status, rpt_ch.packet_sequence);
				errors++;
			end else begin
				want = frame_reports_due.pop_front();
				check_field("frame_status", 32'(want.frame_status), 32'(rpt_ch.frame_status));
				check_field("packet_sequence", 32'(want.packet_sequence),
					32'(rpt_ch.packet_sequence));
				check_field("good_count", want.good_count, rpt_ch.good_count);
				check_field("bad_count", want.bad_count, rpt_ch.bad_count);
			end
		end
	end

	// Report side: random stall bursts, a long hold-off on request, and none
	// at all in the steady part at the end.
	initial begin
		rpt_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_served != hold_requests) begin
				holds_served = holds_served + 1;
				hold_left    = HOLD_CYC - 1;
				rpt_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left = hold_left - 1;
				rpt_ch.ready <= 1'b0;
			end else if (steady_run) begin
				rpt_ch.ready <= 1'b1;
			end else if (sink_gap > 0) begin
				sink_gap = sink_gap - 1;
				rpt_ch.ready <= 1'b0;
			end else if ($urandom_range(0, 99) < 10) begin
				sink_gap = $urandom_range(1, 19) - 1;
				rpt_ch.ready <= 1'b0;
			end else begin
				rpt_ch.ready <= 1'b1;
			end
		end
	end

	// One APB transfer: setup cycle, then access until pready.
	task automatic apb_access(input logic wr, input logic idx, input logic [31:0] wdata,
		output logic [31:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Write a register, mirror it, and read it back.
	task automatic write_reg(input logic idx, input logic [31:0] value);
		logic [31:0] rd;
		logic [31:0] want;
		apb_access(1'b1, idx, value, rd);
		if (idx == TFV_REG_MAGIC) begin
			cfg_magic = value;
		end else begin
			cfg_seed = value[15:0];
		end
		want = (idx == TFV_REG_MAGIC) ? cfg_magic : {16'h0000, cfg_seed};
		apb_access(1'b0, idx, 32'h0, rd);
		check_field("prdata", want, rd);
	endtask

	// Drop valid so that nothing more is taken while the sender waits.
	task automatic rx_idle();
		@(negedge clk);
		rx_ch.valid <= 1'b0;
	endtask

	// Hold the sender until every pending report is out, then let the
	// pipeline settle.
	task automatic drain_reports();
		rx_idle();
		while (frame_reports_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// Offer one beat, wait for the handshake, and advance the model.
	task automatic send_beat(input tfv_beat_t beat);
		tfv_report_t rpt;
		@(negedge clk);
		if (!steady_run && $urandom_range(0, 99) < 8) begin
			rx_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		rx_ch.valid     <= 1'b1;
		rx_ch.data_byte <= beat.data_byte;
		rx_ch.last_byte <= beat.last_byte;
		rx_ch.read_fail <= beat.read_fail;
		do @(posedge clk); while (rx_ch.ready !== 1'b1);
		beats_sent++;
		if (frame_check_step(beat, rpt)) begin
			frame_reports_due.push_back(report_typed ? typed_value : rpt);
			frames_done++;
		end
	endtask

	// Build a frame under the current register settings. A well-formed frame
	// carries the magic word, the sequence in bytes 6 and 7, and a valid CRC
	// trailer; the flags corrupt it on purpose.
	task automatic build_frame(input int len, input logic [15:0] seq, input bit bad_magic,
		input bit bad_crc, input bit rfail, input bit noise);
		logic [15:0] crc;
		int          k;
		int          span;
		span = (len > FRAME_LEN) ? len : FRAME_LEN;
		for (int i = 0; i < span; i++) begin
			frame_beats[i].data_byte = 8'($urandom);
			frame_beats[i].last_byte = 1'b0;
			frame_beats[i].read_fail = 1'b0;
			if (i < 4) begin
				frame_beats[i].data_byte = cfg_magic[8*i +: 8];
			end else if (i == 6) begin
				frame_beats[i].data_byte = seq[7:0];
			end else if (i == 7) begin
				frame_beats[i].data_byte = seq[15:8];
			end
		end
		if (bad_magic) begin
			k = $urandom_range(0, 3);
			frame_beats[k].data_byte ^= 8'h01 << $urandom_range(0, 7);
		end
		crc = cfg_seed;
		for (int i = 0; i < FRAME_LEN - 2; i++) begin
			crc = ccitt_update(crc, frame_beats[i].data_byte);
		end
		frame_beats[FRAME_LEN-2].data_byte = crc[7:0];
		frame_beats[FRAME_LEN-1].data_byte = crc[15:8];
		// flip past the sequence bytes so that the sequence stays as given
		if (bad_crc) begin
			k = $urandom_range(8, FRAME_LEN - 1);
			frame_beats[k].data_byte ^= 8'h01 << $urandom_range(0, 7);
		end
		if (noise) begin
			for (int i = 0; i < len; i++) begin
				frame_beats[i].data_byte = 8'($urandom);
				frame_beats[i].last_byte = ($urandom_range(0, 99) < 20);
				frame_beats[i].read_fail = ($urandom_range(0, 99) < 10);
			end
		end
		if (rfail) begin
			frame_beats[$urandom_range(0, len - 1)].read_fail = 1'b1;
		end
		frame_beats[len-1].last_byte = 1'b1;
		frame_len = len;
	endtask

	task automatic send_frame(input bit typed, input tfv_report_t typed_rpt);
		report_typed = typed;
		typed_value  = typed_rpt;
		for (int i = 0; i < frame_len; i++) begin
			send_beat(frame_beats[i]);
		end
		report_typed = 1'b0;
	endtask

	// Pick a random frame shape, weighted toward well-formed frames.
	task automatic send_random_frame();
		int pick;
		int len;
		bit bm;
		bit bc;
		bit rf;
		bit nz;
		pick = $urandom_range(0, 99);
		len  = FRAME_LEN;
		bm   = 1'b0;
		bc   = 1'b0;
		rf   = 1'b0;
		nz   = 1'b0;
		if (pick >= 87) begin
			nz  = 1'b1;
			len = $urandom_range(1, 64);
		end else if (pick >= 72) begin
			case ($urandom_range(0, 3))
				0, 1: len = $urandom_range(1, FRAME_LEN - 1);
				2: len = $urandom_range(FRAME_LEN + 1, FRAME_LEN + 12);
				default: len = $urandom_range(FRAME_LEN + 13, 2 * FRAME_LEN);
			endcase
			rf = ($urandom_range(0, 3) == 0);
		end else if (pick >= 65) begin
			rf = 1'b1;
			bm = 1'($urandom_range(0, 1));
			bc = 1'($urandom_range(0, 1));
		end else if (pick >= 55) begin
			bc = 1'b1;
		end else if (pick >= 45) begin
			bm = 1'b1;
			bc = 1'($urandom_range(0, 1));
		end
		// now and then, hold the sender until the block has emptied
		if (!steady_run && $urandom_range(0, 99) < 4) begin
			drain_reports();
		end
		build_frame(len, 16'($urandom), bm, bc, rf, nz);
		send_frame(1'b0, '0);
	endtask

	initial begin : stimulus
		logic [31:0] phase_magic [PHASES];
		logic [15:0] phase_seed [PHASES];
		int          beats_start;
		int          frames_start;

		// Drive every input to a known value before the first edge.
		arst_n          = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		rx_ch.valid     = 1'b0;
		rx_ch.data_byte = 8'h00;
		rx_ch.last_byte = 1'b0;
		rx_ch.read_fail = 1'b0;
		report_typed    = 1'b0;
		typed_value     = '0;
		cfg_magic       = TFV_MAGIC_RST;
		cfg_seed        = TFV_SEED_RST;
		accepted_cnt    = 32'd0;
		rejected_cnt    = 32'd0;
		frame_restart();

		// Hand-written frames under the reset settings; the report fields are
		// status, sequence, good count, bad count.
		dir_table = '{
			// single byte: length error, nothing captured
			'{1,         16'h0000, 0, 0, 0, 0, 1, '{TFV_ST_LEN,   16'h0000, 32'd0, 32'd1}},
			'{FRAME_LEN, 16'hFFFF, 0, 0, 0, 0, 1, '{TFV_ST_GOOD,  16'hFFFF, 32'd1, 32'd1}},
			// short frame: only byte 6 arrived
			'{7,         16'h1234, 0, 0, 0, 0, 1, '{TFV_ST_LEN,   16'h0034, 32'd1, 32'd2}},
			'{6,         16'h1234, 0, 0, 0, 0, 1, '{TFV_ST_LEN,   16'h0000, 32'd1, 32'd3}},
			// long enough for the position counter to stop
			'{MAX_FRAME, 16'h00FF, 0, 0, 0, 0, 1, '{TFV_ST_LEN,   16'h00FF, 32'd1, 32'd4}},
			'{FRAME_LEN, 16'h0101, 0, 0, 1, 0, 1, '{TFV_ST_RFAIL, 16'h0101, 32'd1, 32'd5}},
			'{FRAME_LEN, 16'h0202, 1, 0, 0, 0, 1, '{TFV_ST_MAGIC, 16'h0202, 32'd1, 32'd6}},
			'{FRAME_LEN, 16'h0303, 0, 1, 0, 0, 1, '{TFV_ST_CRC,   16'h0303, 32'd1, 32'd7}},
			// several faults at once: the earliest check wins
			'{FRAME_LEN, 16'h0404, 1, 1, 1, 0, 1, '{TFV_ST_RFAIL, 16'h0404, 32'd1, 32'd8}},
			'{FRAME_LEN, 16'h0505, 1, 1, 0, 0, 1, '{TFV_ST_MAGIC, 16'h0505, 32'd1, 32'd9}},
			'{20,        16'h0606, 0, 0, 1, 0, 1, '{TFV_ST_LEN,   16'h0606, 32'd1, 32'd10}},
			'{24,        16'h0000, 0, 0, 0, 1, 0, '0}
		};

		// Settings per random phase: both extremes, the reset values, and
		// random values.
		phase_magic[0] = 32'h0000_0000;
		phase_seed[0]  = 16'h0000;
		phase_magic[1] = 32'hFFFF_FFFF;
		phase_seed[1]  = 16'hFFFF;
		phase_magic[2] = $urandom;
		phase_seed[2]  = 16'($urandom);
		phase_magic[3] = $urandom;
		phase_seed[3]  = 16'($urandom);
		phase_magic[4] = TFV_MAGIC_RST;
		phase_seed[4]  = TFV_SEED_RST;
		phase_magic[5] = $urandom;
		phase_seed[5]  = 16'($urandom);

		// Hold reset, then release it away from the rising edge.
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Walk the directed table.
		for (int r = 0; r < DIR_ROWS; r++) begin
			build_frame(dir_table[r].len, dir_table[r].seq, dir_table[r].bad_magic,
				dir_table[r].bad_crc, dir_table[r].rfail, dir_table[r].noise);
			send_frame(dir_table[r].typed, dir_table[r].exp);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			// Reprogram only once the block has gone idle.
			drain_reports();
			write_reg(TFV_REG_MAGIC, phase_magic[ph]);
			write_reg(TFV_REG_SEED, {16'h0000, phase_seed[ph]});
			steady_run   = (ph == PHASES - 1);
			beats_start  = beats_sent;
			frames_start = frames_done;
			if (ph == 2) begin
				// Hold the report side off and keep offering short frames so
				// that untaken reports back up into rx.
				hold_requests++;
				repeat (10) begin
					build_frame($urandom_range(1, 4), 16'($urandom), 1'b0, 1'b0,
						1'($urandom_range(0, 1)), 1'b0);
					send_frame(1'b0, '0);
				end
			end
			while (beats_sent - beats_start < PHASE_BEATS
				|| frames_done - frames_start < PHASE_FRAMES) begin
				send_random_frame();
			end
		end

		drain_reports();
		if (errors == 0) begin
			$display("PASS telemetry_frame_validator");
		end else begin
			$display("FAIL telemetry_frame_validator");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/tfv_pkg.sv
hw/rtl/tfv_rx_if.sv
hw/rtl/tfv_report_if.sv
hw/rtl/tfv_cfg_regs.sv
hw/rtl/tfv_frame_check.sv
hw/rtl/telemetry_frame_validator.sv
tb/sv/testbench.sv
